FILE: src/swcs_pkg.sv
`default_nettype none

package swcs_pkg;

    localparam int unsigned SEQ_W = 32;
    localparam int unsigned WIN_W = 9;

    localparam logic [WIN_W:0] WINDOW_LIMIT = 10'd256;

    localparam logic [WIN_W-1:0] INIT_THRESHOLD_RESET = 9'd16;
    localparam logic [WIN_W-1:0] MAX_WINDOW_RESET     = 9'd200;

    localparam logic [1:0] OP_OFFER   = 2'd0;
    localparam logic [1:0] OP_PACKET  = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_SEND    = 3'd1;
    localparam logic [2:0] ACT_RESEND  = 3'd2;
    localparam logic [2:0] ACT_DONE    = 3'd3;
    localparam logic [2:0] ACT_REFUSED = 3'd4;

    localparam logic [1:0] MODE_CODE_SEND   = 2'd0;
    localparam logic [1:0] MODE_CODE_FULL   = 2'd1;
    localparam logic [1:0] MODE_CODE_WAIT   = 2'd2;
    localparam logic [1:0] MODE_CODE_RESEND = 2'd3;

    localparam logic REG_INITIAL_THRESHOLD = 1'b0;
    localparam logic REG_MAX_WINDOW        = 1'b1;

    typedef enum logic [3:0] {
        MODE_SEND   = 4'b0001,
        MODE_FULL   = 4'b0010,
        MODE_WAIT   = 4'b0100,
        MODE_RESEND = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [1:0]       operation;
        logic             last_segment;
        logic             is_ack;
        logic [SEQ_W-1:0] ack_number;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       action;
        logic [SEQ_W-1:0] seq_out;
        logic [WIN_W-1:0] window_out;
        logic [WIN_W-1:0] threshold_out;
        logic [1:0]       mode_out;
    } out_item_t;

endpackage

`default_nettype wire

FILE: src/sliding_window_congestion_sender.sv
// Go-back-N sender control with a slow-start congestion window.
// Input channel (s_valid, s_ready, s_item): one event per transaction, either
// a segment offer, a received packet or a receive timeout.
// Result channel (m_valid, m_ready, m_item): exactly one result transaction
// per event, carrying the action, the sequence number to transmit and the
// window, threshold and mode after the event.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the
// initial threshold (index 0, also loaded into the threshold) and the window
// cap (index 1); it is always ready. The user must use it only while the block
// is idle; the block itself does not enforce this. An event waits in the input
// register and its result shows on m_item from the result register.
// Throughput: one event per cycle while each result is taken without a stall.
// Reset (aresetn low, synchronous) empties both registers, restores the
// configuration defaults and returns the sender to send mode with window 1.
// When the receiver stalls, the result is held, one more event may wait in
// the input register, and then s_ready drops until the result is taken.
`default_nettype none

module sliding_window_congestion_sender (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_valid,
    output logic                      s_ready,
    input  wire swcs_pkg::in_item_t   s_item,
    output logic                      m_valid,
    input  wire                       m_ready,
    output swcs_pkg::out_item_t       m_item,
    input  wire                       cfg_valid,
    output logic                      cfg_ready,
    input  wire                       cfg_index,
    input  wire [8:0]                 cfg_data
);
    import swcs_pkg::*;

    in_item_t          in_item_reg;
    logic              in_valid_reg, in_valid_next;
    out_item_t         m_item_reg, m_item_next;
    logic              m_valid_reg, m_valid_next;

    logic [SEQ_W-1:0]  next_seq_reg, next_seq_next;
    logic [SEQ_W-1:0]  base_reg, base_next;
    logic [WIN_W-1:0]  cwnd_reg, cwnd_next;
    logic [WIN_W-1:0]  ssthresh_reg, ssthresh_next;
    logic [WIN_W-1:0]  acks_reg, acks_next;
    mode_t             mode_reg, mode_next;
    logic              offered_reg, offered_next;
    logic [WIN_W-1:0]  init_thr_reg, init_thr_next;
    logic [WIN_W-1:0]  max_win_reg, max_win_next;

    logic              proc;
    logic              s_fire;

    assign proc      = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc;
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        logic [WIN_W-1:0] acks_inc;
        logic [WIN_W:0]   grown;
        logic [WIN_W:0]   cap;
        logic [SEQ_W-1:0] ack_next_base;
        logic [SEQ_W-1:0] base_eff;
        logic             timeout;
        logic             good;
        logic [2:0]       act;
        logic [SEQ_W-1:0] seq;
        logic [1:0]       mode_code;

        in_valid_next = s_fire || (in_valid_reg && !proc);
        m_valid_next  = proc || (m_valid_reg && !m_ready);
        m_item_next   = m_item_reg;
        next_seq_next = next_seq_reg;
        base_next     = base_reg;
        cwnd_next     = cwnd_reg;
        ssthresh_next = ssthresh_reg;
        acks_next     = acks_reg;
        mode_next     = mode_reg;
        offered_next  = offered_reg;
        init_thr_next = init_thr_reg;
        max_win_next  = max_win_reg;

        acks_inc      = acks_reg + 9'd1;
        grown         = (cwnd_reg < ssthresh_reg) ? {cwnd_reg, 1'b0}
                                                  : {1'b0, cwnd_reg} + 10'd1;
        cap           = ({1'b0, max_win_reg} > WINDOW_LIMIT) ? WINDOW_LIMIT
                                                             : {1'b0, max_win_reg};
        if (cap == '0) begin
            cap = 10'd1;
        end
        ack_next_base = in_item_reg.ack_number + 32'd1;
        timeout       = (in_item_reg.operation == OP_TIMEOUT);
        good          = (in_item_reg.operation == OP_PACKET) && in_item_reg.is_ack &&
                        ((in_item_reg.ack_number - base_reg) < (next_seq_reg - base_reg));
        base_eff      = good ? ack_next_base : base_reg;
        act           = ACT_NONE;
        seq           = '0;
        mode_code     = MODE_CODE_SEND;

        if (proc) begin
            case (in_item_reg.operation)
                OP_OFFER: begin
                    if (mode_reg == MODE_SEND) begin
                        act           = ACT_SEND;
                        seq           = next_seq_reg;
                        next_seq_next = next_seq_reg + 32'd1;
                        if (in_item_reg.last_segment) begin
                            offered_next = 1'b1;
                            mode_next    = MODE_WAIT;
                        end else if ((next_seq_next - base_reg) >=
                                     {{(SEQ_W-WIN_W){1'b0}}, cwnd_reg}) begin
                            mode_next = MODE_FULL;
                        end
                    end else begin
                        act = ACT_REFUSED;
                    end
                end
                OP_PACKET, OP_TIMEOUT: begin
                    case (mode_reg)
                        MODE_FULL, MODE_WAIT: begin
                            if (timeout) begin
                                ssthresh_next = (cwnd_reg[WIN_W-1:1] == '0) ? 9'd1
                                              : {1'b0, cwnd_reg[WIN_W-1:1]};
                                acks_next     = '0;
                                cwnd_next     = 9'd1;
                                mode_next     = MODE_RESEND;
                                act           = ACT_RESEND;
                                seq           = base_reg;
                            end else if (good) begin
                                base_next = ack_next_base;
                                if (acks_inc >= cwnd_reg) begin
                                    acks_next = '0;
                                    cwnd_next = (grown > cap) ? cap[WIN_W-1:0]
                                                              : grown[WIN_W-1:0];
                                end else begin
                                    acks_next = acks_inc;
                                end
                                if (mode_reg == MODE_FULL) begin
                                    mode_next = MODE_SEND;
                                end else if (ack_next_base == next_seq_reg) begin
                                    mode_next    = MODE_SEND;
                                    offered_next = 1'b0;
                                    act          = ACT_DONE;
                                end
                            end
                        end
                        MODE_RESEND: begin
                            if (timeout) begin
                                ssthresh_next = (cwnd_reg[WIN_W-1:1] == '0) ? 9'd1
                                              : {1'b0, cwnd_reg[WIN_W-1:1]};
                                acks_next     = '0;
                                cwnd_next     = 9'd1;
                            end else begin
                                base_next = base_eff;
                            end
                            if (base_next == next_seq_reg) begin
                                mode_next = MODE_SEND;
                                if (offered_reg) begin
                                    offered_next = 1'b0;
                                    act          = ACT_DONE;
                                end
                            end else begin
                                act = ACT_RESEND;
                                seq = base_next;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase

            case (mode_next)
                MODE_SEND:   mode_code = MODE_CODE_SEND;
                MODE_FULL:   mode_code = MODE_CODE_FULL;
                MODE_WAIT:   mode_code = MODE_CODE_WAIT;
                MODE_RESEND: mode_code = MODE_CODE_RESEND;
                default:     mode_code = MODE_CODE_SEND;
            endcase

            m_item_next.action        = act;
            m_item_next.seq_out       = seq;
            m_item_next.window_out    = cwnd_next;
            m_item_next.threshold_out = ssthresh_next;
            m_item_next.mode_out      = mode_code;
        end

        if (cfg_valid) begin
            case (cfg_index)
                REG_INITIAL_THRESHOLD: begin
                    init_thr_next = cfg_data;
                    ssthresh_next = (cfg_data == '0) ? 9'd1 : cfg_data;
                end
                REG_MAX_WINDOW: begin
                    max_win_next = cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= s_item;
        end
        m_item_reg <= m_item_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            next_seq_reg <= '0;
            base_reg     <= '0;
            cwnd_reg     <= 9'd1;
            ssthresh_reg <= INIT_THRESHOLD_RESET;
            acks_reg     <= '0;
            mode_reg     <= MODE_SEND;
            offered_reg  <= 1'b0;
            init_thr_reg <= INIT_THRESHOLD_RESET;
            max_win_reg  <= MAX_WINDOW_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            next_seq_reg <= next_seq_next;
            base_reg     <= base_next;
            cwnd_reg     <= cwnd_next;
            ssthresh_reg <= ssthresh_next;
            acks_reg     <= acks_next;
            mode_reg     <= mode_next;
            offered_reg  <= offered_next;
            init_thr_reg <= init_thr_next;
            max_win_reg  <= max_win_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/swcs_checker.sv
`default_nettype none

module swcs_checker (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       m_valid,
    input  wire                       m_ready,
    input  wire swcs_pkg::out_item_t  m_item
);
    import swcs_pkg::*;

    // A stalled result transaction must stay on the port unchanged.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    a_window_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.window_out != '0 && m_item.threshold_out != '0)
        else $error("window or threshold reported as zero");

    a_send_not_resend: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.action == ACT_SEND |-> m_item.mode_out != MODE_CODE_RESEND)
        else $error("new segment sent while in resend mode");

    a_done_in_send: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.action == ACT_DONE |-> m_item.mode_out == MODE_CODE_SEND)
        else $error("message done without returning to send mode");

    a_seq_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.action != ACT_SEND && m_item.action != ACT_RESEND
        |-> m_item.seq_out == '0)
        else $error("sequence number reported without a transmission");

endmodule

bind sliding_window_congestion_sender swcs_checker u_swcs_checker (.*);

`default_nettype wire

FILE: sim/sliding_window_congestion_sender_tb.sv
`default_nettype none

module sliding_window_congestion_sender_tb;

    import swcs_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned PHASES = 7;
    localparam int unsigned EVENTS_PER_PHASE = 100;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned HOLD_AFTER = 250;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    in_item_t         s_item = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    out_item_t        m_item;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_index = REG_INITIAL_THRESHOLD;
    logic [WIN_W-1:0] cfg_data = '0;

    in_item_t  pending_events[$];
    out_item_t expected_results[$];
    int unsigned failures = 0;
    int unsigned results_checked = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_left = 0;
    logic        held_once = 1'b0;
    logic        steady = 1'b0;

    // Sender state as predicted by the testbench.
    logic [SEQ_W-1:0] next_seq;
    logic [SEQ_W-1:0] win_base;
    logic [WIN_W-1:0] cwnd;
    logic [WIN_W-1:0] ssthresh;
    logic [WIN_W-1:0] acks_seen;
    logic [1:0]       mode;
    logic             msg_open;
    logic [WIN_W-1:0] max_win;

    logic [WIN_W-1:0] thr_plan [PHASES] = '{9'd0, 9'd1, 9'd256, 9'd511, 9'd4, 9'd16, 9'd40};
    logic [WIN_W-1:0] cap_plan [PHASES] = '{9'd0, 9'd1, 9'd256, 9'd511, 9'd8, 9'd200, 9'd60};

    sliding_window_congestion_sender dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic void start_resend();
        ssthresh = (cwnd < 9'd2) ? 9'd1 : (cwnd >> 1);
        acks_seen = '0;
        cwnd = 9'd1;
        mode = MODE_CODE_RESEND;
    endfunction

    function automatic out_item_t advance_sender(input in_item_t ev);
        out_item_t        r;
        logic             timeout;
        logic             good;
        logic [SEQ_W-1:0] ack_span;
        logic [SEQ_W-1:0] flight;
        logic [WIN_W:0]   grown;
        logic [WIN_W:0]   cap;
        r = '0;
        r.action = ACT_NONE;
        timeout = (ev.operation == OP_TIMEOUT);
        ack_span = ev.ack_number - win_base;
        flight = next_seq - win_base;
        good = !timeout && ev.is_ack && (ack_span < flight);
        if (ev.operation == OP_OFFER) begin
            if (mode == MODE_CODE_SEND) begin
                r.action = ACT_SEND;
                r.seq_out = next_seq;
                next_seq = next_seq + 1;
                flight = next_seq - win_base;
                if (ev.last_segment) begin
                    msg_open = 1'b1;
                    mode = MODE_CODE_WAIT;
                end else if (flight >= {23'd0, cwnd}) begin
                    mode = MODE_CODE_FULL;
                end
            end else begin
                r.action = ACT_REFUSED;
            end
        end else if (ev.operation == OP_PACKET || ev.operation == OP_TIMEOUT) begin
            if (mode == MODE_CODE_FULL || mode == MODE_CODE_WAIT) begin
                if (timeout) begin
                    start_resend();
                    r.action = ACT_RESEND;
                    r.seq_out = win_base;
                end else if (good) begin
                    win_base = ev.ack_number + 1;
                    acks_seen = acks_seen + 9'd1;
                    if (acks_seen >= cwnd) begin
                        grown = (cwnd < ssthresh) ? {cwnd, 1'b0} : ({1'b0, cwnd} + 10'd1);
                        cap = ({1'b0, max_win} > WINDOW_LIMIT) ? WINDOW_LIMIT : {1'b0, max_win};
                        if (cap == '0) begin
                            cap = 10'd1;
                        end
                        acks_seen = '0;
                        cwnd = (grown > cap) ? cap[WIN_W-1:0] : grown[WIN_W-1:0];
                    end
                    if (mode == MODE_CODE_FULL) begin
                        mode = MODE_CODE_SEND;
                    end else if (win_base == next_seq) begin
                        mode = MODE_CODE_SEND;
                        msg_open = 1'b0;
                        r.action = ACT_DONE;
                    end
                end
            end else if (mode == MODE_CODE_RESEND) begin
                if (timeout) begin
                    start_resend();
                end else if (good) begin
                    win_base = ev.ack_number + 1;
                end
                if (win_base == next_seq) begin
                    mode = MODE_CODE_SEND;
                    if (msg_open) begin
                        msg_open = 1'b0;
                        r.action = ACT_DONE;
                    end
                end else begin
                    r.action = ACT_RESEND;
                    r.seq_out = win_base;
                end
            end
        end
        r.window_out = cwnd;
        r.threshold_out = ssthresh;
        r.mode_out = mode;
        return r;
    endfunction

    // Random events are shaped by the predicted state so that most of them are
    // acceptable acknowledgements or offers that the sender can take.
    function automatic in_item_t make_event();
        in_item_t         ev;
        logic [SEQ_W-1:0] flight;
        int unsigned      roll;
        ev.operation = OP_PACKET;
        ev.last_segment = 1'($urandom_range(1));
        ev.is_ack = 1'b1;
        ev.ack_number = $urandom;
        flight = next_seq - win_base;
        roll = $urandom_range(99);
        if (roll < 6) begin
            ev.operation = 2'($urandom_range(3));
            ev.is_ack = 1'($urandom_range(1));
        end else if (mode == MODE_CODE_SEND) begin
            if (roll < 88) begin
                ev.operation = OP_OFFER;
                ev.last_segment = ($urandom_range(99) < 12);
            end else begin
                ev.operation = ($urandom_range(1) == 0) ? OP_PACKET : OP_TIMEOUT;
            end
        end else begin
            roll = $urandom_range(99);
            if (roll < 72 && flight != '0) begin
                ev.ack_number = win_base + (($urandom_range(2) == 0) ? ($urandom % flight) : 0);
            end else if (roll < 82) begin
                ev.operation = OP_TIMEOUT;
            end else if (roll < 90) begin
                ev.is_ack = 1'b0;
            end else if (roll >= 95) begin
                ev.operation = OP_OFFER;
            end
        end
        return ev;
    endfunction

    task automatic add_event(input logic [1:0] op, input logic last, input logic ack_flag,
                             input logic [SEQ_W-1:0] number);
        in_item_t ev;
        ev.operation = op;
        ev.last_segment = last;
        ev.is_ack = ack_flag;
        ev.ack_number = number;
        pending_events.push_back(ev);
    endtask

    task automatic write_register(input logic idx, input logic [WIN_W-1:0] value);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_INITIAL_THRESHOLD) begin
            ssthresh = (value == '0) ? 9'd1 : value;
        end else begin
            max_win = value;
        end
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_events.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (3) @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(advance_sender(s_item));
            end
            if (!s_valid || s_ready) begin
                if (pending_events.size() != 0 && (steady || $urandom_range(99) >= 28)) begin
                    s_valid <= 1'b1;
                    s_item <= pending_events.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_checked++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction: action %0d seq %0d",
                           m_item.action, m_item.seq_out);
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_item.action !== want.action) begin
                        $error("action: expected %0d, actual %0d", want.action, m_item.action);
                        failures++;
                    end
                    if (m_item.seq_out !== want.seq_out) begin
                        $error("seq_out: expected %0d, actual %0d", want.seq_out, m_item.seq_out);
                        failures++;
                    end
                    if (m_item.window_out !== want.window_out) begin
                        $error("window_out: expected %0d, actual %0d",
                               want.window_out, m_item.window_out);
                        failures++;
                    end
                    if (m_item.threshold_out !== want.threshold_out) begin
                        $error("threshold_out: expected %0d, actual %0d",
                               want.threshold_out, m_item.threshold_out);
                        failures++;
                    end
                    if (m_item.mode_out !== want.mode_out) begin
                        $error("mode_out: expected %0d, actual %0d", want.mode_out, m_item.mode_out);
                        failures++;
                    end
                end
                if (results_checked == HOLD_AFTER && !held_once) begin
                    held_once = 1'b1;
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 28);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        next_seq = '0;
        win_base = '0;
        cwnd = 9'd1;
        max_win = MAX_WINDOW_RESET;
        ssthresh = INIT_THRESHOLD_RESET;
        acks_seen = '0;
        mode = MODE_CODE_SEND;
        msg_open = 1'b0;
        thr_plan[PHASES-1] = 9'($urandom_range(1, 256));
        cap_plan[PHASES-1] = 9'($urandom_range(1, 256));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        add_event(OP_UNUSED, 1'b1, 1'b1, 32'hFFFF_FFFF);
        add_event(OP_TIMEOUT, 1'b0, 1'b0, 32'd0);
        add_event(OP_PACKET, 1'b0, 1'b1, 32'd0);
        add_event(OP_OFFER, 1'b0, 1'b0, 32'd0);
        add_event(OP_OFFER, 1'b1, 1'b1, 32'hFFFF_FFFF);
        add_event(OP_PACKET, 1'b0, 1'b0, 32'd0);
        add_event(OP_PACKET, 1'b0, 1'b1, 32'hFFFF_FFFF);
        add_event(OP_PACKET, 1'b0, 1'b1, 32'd0);
        add_event(OP_OFFER, 1'b0, 1'b0, 32'd0);
        add_event(OP_OFFER, 1'b1, 1'b0, 32'd0);
        add_event(OP_TIMEOUT, 1'b0, 1'b0, 32'd0);
        add_event(OP_PACKET, 1'b0, 1'b0, 32'd1);
        add_event(OP_PACKET, 1'b0, 1'b1, 32'd1);
        add_event(OP_TIMEOUT, 1'b0, 1'b1, 32'd1);
        add_event(OP_PACKET, 1'b0, 1'b1, 32'd2);
        add_event(OP_OFFER, 1'b1, 1'b0, 32'd0);
        add_event(OP_PACKET, 1'b0, 1'b1, 32'd3);
        add_event(OP_OFFER, 1'b0, 1'b0, 32'd0);
        add_event(OP_OFFER, 1'b0, 1'b0, 32'd0);
        add_event(OP_TIMEOUT, 1'b0, 1'b0, 32'd0);
        add_event(OP_TIMEOUT, 1'b0, 1'b0, 32'd0);
        add_event(OP_PACKET, 1'b0, 1'b1, 32'd5);

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            write_register(REG_INITIAL_THRESHOLD, thr_plan[p]);
            write_register(REG_MAX_WINDOW, cap_plan[p]);
            steady = (p == 3);
            for (int k = 0; k < EVENTS_PER_PHASE; k++) begin
                do @(negedge aclk); while (pending_events.size() >= 2);
                pending_events.push_back(make_event());
            end
        end

        wait_idle();
        repeat (5) @(negedge aclk);
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
